/* rtl/base64_stream_decoder_core_assert.svh */
// assertion macros shared by the decoder modules
`ifndef BASE64_STREAM_DECODER_CORE_ASSERT_SVH
`define BASE64_STREAM_DECODER_CORE_ASSERT_SVH

`ifndef SYNTH
`define B64D_ASSERT(name, cond) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("assertion failed");
`define B64D_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define B64D_ASSERT(name, cond)
`define B64D_ASSERT_NEXT(name, ante, cons)
`endif

`endif

/* rtl/b64d_pkg.sv */
// shared types and constants of the base64 stream decoder
package b64d_pkg;

    localparam int B64D_QUEUE_DEPTH = 4;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALT_SYMS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_WS = 1'd1;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_BAD_CHAR = 2'd1;
    localparam logic [1:0] ST_BAD_TAIL = 2'd2;

    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } t_in_req;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       out_last;
        logic [1:0] status;
    } t_out_req;

    typedef enum logic [1:0] {
        TK_DATA,
        TK_PAD,
        TK_SKIP,
        TK_BAD
    } t_tok_kind;

    typedef struct packed {
        t_tok_kind  kind;
        logic [5:0] sextet;
        logic       last;
    } t_tok;

endpackage

/* rtl/b64d_front.sv */
// front end: configuration registers and character classification
module b64d_front
    import b64d_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_req               i_in,
    output t_tok                  o_tok
);

    localparam logic [7:0] CH_UP_A = 8'h41;
    localparam logic [7:0] CH_UP_Z = 8'h5a;
    localparam logic [7:0] CH_LO_A = 8'h61;
    localparam logic [7:0] CH_LO_Z = 8'h7a;
    localparam logic [7:0] CH_D0 = 8'h30;
    localparam logic [7:0] CH_D9 = 8'h39;
    localparam logic [7:0] CH_PLUS = 8'h2b;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_USCORE = 8'h5f;
    localparam logic [7:0] CH_EQ = 8'h3d;
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_LF = 8'h0a;

    logic r_alt_syms;
    logic r_skip_ws;
    logic [7:0] w_c;
    logic w_space;
    logic [7:0] w_c62;
    logic [7:0] w_c63;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alt_syms <= 1'b0;
            r_skip_ws  <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_ALT_SYMS) begin
                r_alt_syms <= i_cfg_data[0];
            end
            if (i_cfg_idx == CFG_SKIP_WS) begin
                r_skip_ws <= i_cfg_data[0];
            end
        end
    end

    assign w_c     = i_in.in_char;
    assign w_space = (w_c == CH_SP) || (w_c == CH_TAB) || (w_c == CH_CR) || (w_c == CH_LF);
    assign w_c62   = r_alt_syms ? CH_MINUS : CH_PLUS;
    assign w_c63   = r_alt_syms ? CH_USCORE : CH_SLASH;

    always_comb begin
        o_tok.last   = i_in.in_last;
        o_tok.sextet = 6'd0;
        o_tok.kind   = TK_BAD;
        if (r_skip_ws && w_space) begin
            o_tok.kind = TK_SKIP;
        end else if (w_c == CH_EQ) begin
            o_tok.kind = TK_PAD;
        end else if (w_c >= CH_UP_A && w_c <= CH_UP_Z) begin
            o_tok.kind   = TK_DATA;
            o_tok.sextet = 6'(w_c - CH_UP_A);
        end else if (w_c >= CH_LO_A && w_c <= CH_LO_Z) begin
            o_tok.kind   = TK_DATA;
            o_tok.sextet = 6'(w_c - CH_LO_A + 8'd26);
        end else if (w_c >= CH_D0 && w_c <= CH_D9) begin
            o_tok.kind   = TK_DATA;
            o_tok.sextet = 6'(w_c - CH_D0 + 8'd52);
        end else if (w_c == w_c62) begin
            o_tok.kind   = TK_DATA;
            o_tok.sextet = 6'd62;
        end else if (w_c == w_c63) begin
            o_tok.kind   = TK_DATA;
            o_tok.sextet = 6'd63;
        end
    end

endmodule

/* rtl/b64d_queue.sv */
// token queue between the front and back ends
`include "base64_stream_decoder_core_assert.svh"

module b64d_queue
    import b64d_pkg::*;
#(
    parameter int DEPTH = B64D_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_tok i_tok,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_tok o_tok
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_tok r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_tok   = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_tok;
        end
    end

    `B64D_ASSERT(a_count_bound, r_count <= FULL_CNT)
    `B64D_ASSERT(a_no_overflow, !(i_push && o_full))
    `B64D_ASSERT(a_no_underflow, !(i_pop && !o_valid))

endmodule

/* rtl/b64d_back.sv */
// back end: bit packing, message status and output register
`include "base64_stream_decoder_core_assert.svh"

module b64d_back
    import b64d_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_tok_valid,
    input  t_tok     i_tok,
    output logic     o_pop,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out_req o_out
);

    logic [5:0] r_residue;
    logic [2:0] r_pending;
    logic       r_pad;
    logic       r_err;
    logic       r_out_valid;
    t_out_req   r_out;

    logic [5:0] n_residue;
    logic [2:0] n_pending;
    logic       n_pad;
    logic       n_err;

    logic [11:0] w_acc;
    logic [3:0]  w_sum;
    logic [3:0]  w_cnt;
    logic [11:0] w_mask;
    logic        w_have;
    logic [7:0]  w_byte;
    logic [1:0]  w_status;
    logic        w_emit;

    assign w_acc  = {r_residue, i_tok.sextet};
    assign w_sum  = {1'b0, r_pending} + 4'd6;
    assign w_cnt  = w_sum[3] ? (w_sum - 4'd8) : w_sum;
    assign w_mask = (12'd1 << w_cnt) - 12'd1;

    assign o_pop = i_tok_valid && (!r_out_valid || i_out_ready);

    always_comb begin
        n_residue = r_residue;
        n_pending = r_pending;
        n_pad     = r_pad;
        n_err     = r_err;
        w_have    = 1'b0;
        w_byte    = 8'd0;
        if (!r_err) begin
            case (i_tok.kind)
                TK_DATA: begin
                    if (r_pad) begin
                        n_err = 1'b1;
                    end else begin
                        w_have    = w_sum[3];
                        w_byte    = w_sum[3] ? 8'(w_acc >> w_cnt) : 8'd0;
                        n_residue = 6'(w_acc & w_mask);
                        n_pending = 3'(w_cnt);
                    end
                end
                TK_PAD: begin
                    n_pad = 1'b1;
                end
                TK_BAD: begin
                    n_err = 1'b1;
                end
                default: begin
                end
            endcase
        end
        if (!i_tok.last) begin
            w_status = ST_OK;
        end else if (n_err) begin
            w_status = ST_BAD_CHAR;
        end else if (n_pending == 3'd6 || (n_pending != 3'd0 && n_residue != 6'd0)) begin
            w_status = ST_BAD_TAIL;
        end else begin
            w_status = ST_OK;
        end
        w_emit = w_have || i_tok.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_residue   <= 6'd0;
            r_pending   <= 3'd0;
            r_pad       <= 1'b0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                if (i_tok.last) begin
                    r_residue <= 6'd0;
                    r_pending <= 3'd0;
                    r_pad     <= 1'b0;
                    r_err     <= 1'b0;
                end else begin
                    r_residue <= n_residue;
                    r_pending <= n_pending;
                    r_pad     <= n_pad;
                    r_err     <= n_err;
                end
            end
            if (o_pop && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_emit) begin
            r_out.out_byte   <= w_byte;
            r_out.byte_valid <= w_have;
            r_out.out_last   <= i_tok.last;
            r_out.status     <= w_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `B64D_ASSERT(a_pending_even, !r_pending[0] && r_pending <= 3'd6)
    `B64D_ASSERT_NEXT(a_last_clears, o_pop && i_tok.last, r_pending == 3'd0 && !r_pad && !r_err)
    `B64D_ASSERT(a_status_only_last, !r_out_valid || r_out.out_last || r_out.status == ST_OK)

endmodule

/* rtl/base64_stream_decoder_core.sv */
// top level of the base64 stream decoder
// a character is held in the token queue, then its result in the back end output register
// throughput: one character per cycle while the output is ready, sustained through the token queue
// a stalled output holds the back end; the front keeps accepting until the queue fills
// reset is synchronous, active low: clears queue, packing state, flags and config
module base64_stream_decoder_core
    import b64d_pkg::*;
#(
    parameter int QUEUE_DEPTH = B64D_QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_req               i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_req              o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_tok w_front_tok;
    t_tok w_queue_tok;
    logic w_full;
    logic w_push;
    logic w_pop;
    logic w_tok_valid;

    assign o_in_ready = !w_full;
    assign w_push     = i_in_valid && !w_full;

    b64d_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .o_tok      (w_front_tok)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_tok   (w_front_tok),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_tok_valid),
        .o_tok   (w_queue_tok)
    );

    b64d_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (w_tok_valid),
        .i_tok       (w_queue_tok),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule
